// ----- sv/sctan_pkg.sv -----
// Shared constants, types and constant functions for the sine/cosine/tangent evaluator.
`default_nettype none

package sctan_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF  = 24;
    localparam int DATA_WIDTH_DEF = 32;

    // working format: 30 fraction bits
    localparam int WF = 30;

    // pi and pi/2 at 30 fraction bits
    localparam logic [63:0] PI_W      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_W = 64'd1686629713;
    // 4/pi, 4/pi^2 and the refinement weight 0.225, all at 30 fraction bits
    localparam logic [63:0] B_W = ((64'd1 << 62) + PI_W / 2) / PI_W;
    localparam logic [63:0] C_W = ((B_W << WF) + PI_W / 2) / PI_W;
    localparam logic [63:0] P_W = 64'd241591910;
    // half an LSB at 30 fraction bits, for round half away from zero
    localparam logic [63:0] RND_W = 64'd1 << (WF - 1);

    // width of a signed working value and of its magnitude
    localparam int YW = 36;
    localparam int MW = 36;

    // function codes
    typedef enum logic [1:0] {
        FUNC_SIN = 2'd0,
        FUNC_COS = 2'd1,
        FUNC_TAN = 2'd2
    } t_func;

    // 30-fraction constant rounded to frac fraction bits
    function automatic logic [63:0] fix_const(input logic [63:0] w30, input int frac);
        int sh;
        logic [63:0] res;
        sh = WF - frac;
        if (sh > 0) begin
            res = (w30 + (64'd1 << (sh - 1))) >> sh;
        end else begin
            res = w30;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sctan_sine.sv -----
// One sine lane: floored reduction into [-pi, pi) then parabolic sine with refinement.
`default_nettype none

module sctan_sine import sctan_pkg::*; #(
    parameter int          DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int          FRAC_BITS  = FRAC_BITS_DEF,
    parameter logic [63:0] OFFSET     = 64'd0
) (
    input  wire logic                         i_clk,
    input  wire logic signed [DATA_WIDTH-1:0] i_angle,
    output logic signed [YW-1:0]              o_y
);

    localparam int          SH       = WF - FRAC_BITS;
    localparam logic [63:0] PI_F     = fix_const(PI_W, FRAC_BITS);
    localparam logic [63:0] TWO_PI_F = PI_F << 1;
    // reduction steps K..0 of 2*pi << k
    localparam int          K        = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH - FRAC_BITS : 0;
    localparam int          VW       = ((DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS) + 4;
    // bias keeps the sum positive; apart from OFFSET and the pi taken off after reduction, it is a multiple of 2*pi
    localparam logic [63:0] BIAS     = (TWO_PI_F << K) + PI_F + OFFSET;

    logic [VW-1:0]        r_red [0:K+1];
    logic signed [33:0]   r_w;
    logic [33:0]          r_p1;
    logic [33:0]          r_p2;
    logic                 r_neg;
    logic signed [YW-1:0] r_y0;
    logic signed [YW:0]   r_u;
    logic signed [YW-1:0] r_y0d;

    // bias the angle
    always_ff @(posedge i_clk) begin
        r_red[0] <= {{(VW-DATA_WIDTH){i_angle[DATA_WIDTH-1]}}, i_angle} + BIAS[VW-1:0];
    end

    // restoring reduction, one multiple of 2*pi a stage
    for (genvar j = 1; j <= K + 1; j++) begin : g_red
        localparam logic [63:0] STEP = TWO_PI_F << (K + 1 - j);
        always_ff @(posedge i_clk) begin
            if (r_red[j-1] >= STEP[VW-1:0]) begin
                r_red[j] <= r_red[j-1] - STEP[VW-1:0];
            end else begin
                r_red[j] <= r_red[j-1];
            end
        end
    end

    // shift back by pi and widen to 30 fraction bits
    logic signed [63:0] n_d;
    logic signed [63:0] n_w;
    always_comb begin
        n_d = $signed(64'(r_red[K+1])) - $signed(PI_F);
        n_w = n_d <<< SH;
    end
    always_ff @(posedge i_clk) begin
        r_w <= n_w[33:0];
    end

    // (4/pi)|w| and w^2
    logic [33:0] n_aw;
    logic [63:0] n_pr1;
    logic [63:0] n_pr2;
    always_comb begin
        n_aw  = r_w[33] ? 34'(-r_w) : r_w;
        n_pr1 = B_W * 64'(n_aw) + RND_W;
        n_pr2 = 64'(n_aw) * 64'(n_aw) + RND_W;
    end
    always_ff @(posedge i_clk) begin
        r_p1  <= n_pr1[63:30];
        r_p2  <= n_pr2[63:30];
        r_neg <= r_w[33];
    end

    // parabola y0 = (4/pi)w - (4/pi^2)w|w|
    logic [63:0]          n_pr3;
    logic signed [YW-1:0] n_df;
    always_comb begin
        n_pr3 = C_W * 64'(r_p2) + RND_W;
        n_df  = $signed({2'b00, r_p1}) - $signed({2'b00, n_pr3[63:30]});
    end
    always_ff @(posedge i_clk) begin
        r_y0 <= r_neg ? -n_df : n_df;
    end

    // u = y0|y0| - y0
    logic [YW-1:0]      n_ay;
    logic [63:0]        n_pr4;
    logic signed [YW:0] n_qs;
    always_comb begin
        n_ay  = r_y0[YW-1] ? YW'(-r_y0) : r_y0;
        n_pr4 = 64'(n_ay) * 64'(n_ay) + RND_W;
        n_qs  = r_y0[YW-1] ? -$signed({3'b000, n_pr4[63:30]})
                           : $signed({3'b000, n_pr4[63:30]});
    end
    always_ff @(posedge i_clk) begin
        r_u   <= n_qs - $signed({r_y0[YW-1], r_y0});
        r_y0d <= r_y0;
    end

    // y = 0.225 u + y0
    logic [YW:0]          n_au;
    logic [63:0]          n_pr5;
    logic signed [YW-1:0] n_vs;
    always_comb begin
        n_au  = r_u[YW] ? (YW+1)'(-r_u) : r_u;
        n_pr5 = P_W * 64'(n_au) + RND_W;
        n_vs  = r_u[YW] ? -$signed({2'b00, n_pr5[63:30]}) : $signed({2'b00, n_pr5[63:30]});
    end
    always_ff @(posedge i_clk) begin
        o_y <= n_vs + r_y0d;
    end

endmodule

`default_nettype wire

// ----- sv/sctan_div.sv -----
// Pipelined restoring divider, one quotient bit a stage, with an overflow check up front.
`default_nettype none

module sctan_div import sctan_pkg::*; #(
    parameter int QW   = DATA_WIDTH_DEF,
    parameter int DENW = MW,
    parameter int RW   = 64
) (
    input  wire logic            i_clk,
    input  wire logic [RW-1:0]   i_num,
    input  wire logic [DENW-1:0] i_den,
    output logic [QW-1:0]        o_quo,
    output logic                 o_big
);

    logic [RW-1:0]   r_rem [0:QW-1];
    logic [DENW-1:0] r_den [0:QW-1];
    logic [QW-1:0]   r_q   [0:QW];
    logic            r_big [0:QW];

    // quotient does not fit in QW bits
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_big[0] <= i_num >= (RW'(i_den) << QW);
    end

    // one quotient bit, most significant first
    for (genvar i = 1; i <= QW; i++) begin : g_bit
        localparam int B = QW - i;
        logic [RW-1:0] dsh;
        logic          ge;
        always_comb begin
            dsh = RW'(r_den[i-1]) << B;
            ge  = r_rem[i-1] >= dsh;
        end
        always_ff @(posedge i_clk) begin
            r_q[i]   <= r_q[i-1] | (QW'(ge) << B);
            r_big[i] <= r_big[i-1];
        end
        if (i < QW) begin : g_pass
            always_ff @(posedge i_clk) begin
                r_rem[i] <= ge ? r_rem[i-1] - dsh : r_rem[i-1];
                r_den[i] <= r_den[i-1];
            end
        end
    end

    assign o_quo = r_q[QW];
    assign o_big = r_big[QW];

endmodule

`default_nettype wire

// ----- sv/sine_cosine_tangent_approx_top.sv -----
// Top level of the pipelined parabolic sine, cosine and tangent evaluator.
//
// Use: drive i_func (sine, cosine, tangent) and a Q(FRAC_BITS) radian angle on
// i_angle with start high; the word is taken at that clock edge. busy is always
// low, so a new word may be started every cycle.
// Each result word appears on o_value and o_overflow for one cycle with o_strobe
// high. The pipeline depth is set by the angle reduction (one multiple of 2*pi
// per stage) and the tangent divider (one quotient bit per stage). Every item
// goes through the full pipeline, so results leave in order.
// Throughput: one word per clock.
// Reset (i_rst_n low, synchronous) clears the valid line; words in flight are
// dropped and no strobe follows. The receiver cannot stall: results are not held.
// An unused function code returns zero with no overflow.
`default_nettype none

module sine_cosine_tangent_approx_top import sctan_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_func,
    input  wire logic signed [DATA_WIDTH-1:0] i_angle,
    output logic signed [DATA_WIDTH-1:0]      o_value,
    output logic                              o_overflow,
    output logic                              o_strobe
);

    localparam int          SH       = WF - FRAC_BITS;
    localparam int          K        = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH - FRAC_BITS : 0;
    localparam int          LS       = K + 7;
    localparam int          LAT      = LS + DATA_WIDTH + 3;
    localparam int          NW       = MW + FRAC_BITS + 1;
    localparam int          RW       = ((NW > MW + DATA_WIDTH) ? NW : MW + DATA_WIDTH) + 1;
    localparam logic [63:0] HALF_F   = fix_const(HALF_PI_W, FRAC_BITS);
    localparam logic [63:0] HALF_LSB = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;
    localparam logic [63:0] NEG_MAG  = 64'd1 << (DATA_WIDTH - 1);
    localparam logic [63:0] POS_MAX  = NEG_MAG - 64'd1;
    localparam logic [DATA_WIDTH-1:0] MAXV = POS_MAX[DATA_WIDTH-1:0];
    localparam logic [DATA_WIDTH-1:0] MINV = NEG_MAG[DATA_WIDTH-1:0];

    typedef struct packed {
        logic                  usediv;
        logic                  neg;
        logic                  ovf;
        logic [DATA_WIDTH-1:0] value;
    } t_tag;

    logic [LAT-1:0]       r_vld;
    logic [1:0]           r_fn [0:LS-1];
    logic signed [YW-1:0] y_sin;
    logic signed [YW-1:0] y_cos;
    t_tag                 r_tag [0:DATA_WIDTH+1];
    logic [RW-1:0]        r_num;
    logic [MW-1:0]        r_den;
    logic [DATA_WIDTH-1:0] quo;
    logic                 big;
    logic signed [DATA_WIDTH-1:0] r_value;
    logic                 r_ovf;

    assign busy = 1'b0;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    // function code follows the sine lanes
    always_ff @(posedge i_clk) begin
        r_fn[0] <= i_func;
        for (int i = 1; i < LS; i++) begin
            r_fn[i] <= r_fn[i-1];
        end
    end

    sctan_sine #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .OFFSET     (64'd0)
    ) u_sin (
        .i_clk   (i_clk),
        .i_angle (i_angle),
        .o_y     (y_sin)
    );

    sctan_sine #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .OFFSET     (HALF_F)
    ) u_cos (
        .i_clk   (i_clk),
        .i_angle (i_angle),
        .o_y     (y_cos)
    );

    // round to output format and saturate: {overflow, value}
    function automatic logic [DATA_WIDTH:0] sat_out(input logic signed [YW-1:0] y);
        logic [YW-1:0] ay;
        logic [63:0]   m;
        logic          ovf;
        ay  = y[YW-1] ? YW'(-y) : y;
        m   = (64'(ay) + HALF_LSB) >> SH;
        ovf = 1'b0;
        if (y[YW-1]) begin
            if (m > NEG_MAG) begin
                ovf = 1'b1;
                m   = NEG_MAG;
            end
            m = -m;
        end else if (m > POS_MAX) begin
            ovf = 1'b1;
            m   = POS_MAX;
        end
        return {ovf, m[DATA_WIDTH-1:0]};
    endfunction

    // sine/cosine results and divider operands
    t_tag                  n_tag;
    logic [DATA_WIDTH:0]   so;
    logic [DATA_WIDTH:0]   co;
    logic [MW-1:0]         as_m;
    logic [MW-1:0]         ac_m;
    always_comb begin
        so   = sat_out(y_sin);
        co   = sat_out(y_cos);
        as_m = y_sin[YW-1] ? MW'(-y_sin) : MW'(y_sin);
        ac_m = y_cos[YW-1] ? MW'(-y_cos) : MW'(y_cos);
        n_tag        = '0;
        n_tag.neg    = y_sin[YW-1] ^ y_cos[YW-1];
        case (r_fn[LS-1])
            FUNC_SIN: begin
                n_tag.ovf   = so[DATA_WIDTH];
                n_tag.value = so[DATA_WIDTH-1:0];
            end
            FUNC_COS: begin
                n_tag.ovf   = co[DATA_WIDTH];
                n_tag.value = co[DATA_WIDTH-1:0];
            end
            FUNC_TAN: begin
                if (y_cos == '0) begin
                    n_tag.ovf   = 1'b1;
                    n_tag.value = y_sin[YW-1] ? MINV : MAXV;
                end else begin
                    n_tag.usediv = 1'b1;
                end
            end
            default: begin
                n_tag.value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= n_tag;
        r_num    <= (RW'(as_m) << FRAC_BITS) + RW'(ac_m >> 1);
        r_den    <= ac_m;
        for (int i = 1; i <= DATA_WIDTH + 1; i++) begin
            r_tag[i] <= r_tag[i-1];
        end
    end

    sctan_div #(
        .QW   (DATA_WIDTH),
        .DENW (MW),
        .RW   (RW)
    ) u_div (
        .i_clk (i_clk),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (quo),
        .o_big (big)
    );

    // final selection and tangent saturation
    t_tag                  tg;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  n_ovf;
    always_comb begin
        tg      = r_tag[DATA_WIDTH+1];
        n_value = tg.value;
        n_ovf   = tg.ovf;
        if (tg.usediv) begin
            if (big || (tg.neg && 64'(quo) > NEG_MAG) || (!tg.neg && 64'(quo) > POS_MAX)) begin
                n_ovf   = 1'b1;
                n_value = tg.neg ? MINV : MAXV;
            end else begin
                n_ovf   = 1'b0;
                n_value = tg.neg ? DATA_WIDTH'(-quo) : quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_ovf   <= n_ovf;
    end

    assign o_value    = r_value;
    assign o_overflow = r_ovf;
    assign o_strobe   = r_vld[LAT-1];

`ifndef NO_ASSERTIONS
    // every result word comes from a started word a fixed latency earlier
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result strobe without a matching start");

    // unused code gives zero without overflow
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_func, LAT) != FUNC_SIN && $past(i_func, LAT) != FUNC_COS
         && $past(i_func, LAT) != FUNC_TAN) |-> (o_value == '0 && !o_overflow))
        else $error("unused function code gave a non-zero result");

    // a saturated sine or cosine sits on a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_overflow && $past(i_func, LAT) != FUNC_TAN)
        |-> (o_value == MAXV || o_value == MINV))
        else $error("overflow flagged off the range limits");
`endif

endmodule

`default_nettype wire
